// ----- hdl/eeg_pkg.sv -----
// Shared widths and types for the extended Euclid gcd core.
// No dependencies; compiled first.
package eeg_pkg;

  // Datapath width: operands carry one bit less, coefficients the full width
  localparam int DATA_WIDTH = 32;
  localparam int OPND_W     = DATA_WIDTH - 1;
  localparam int COEF_W     = DATA_WIDTH;
  localparam int CNT_W      = $clog2(OPND_W);

  typedef logic [OPND_W-1:0]        opnd_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  localparam coef_t COEF_ZERO = coef_t'(0);
  localparam coef_t COEF_ONE  = coef_t'(1);

endpackage

// ----- hdl/eeg_in_if.sv -----
// Operand channel: valid/ready handshake carrying the two operands.
// Depends on eeg_pkg.
interface eeg_in_if import eeg_pkg::*; ();
  logic  valid;
  logic  ready;
  opnd_t a_value;
  opnd_t b_value;

  modport source (output valid, output a_value, output b_value, input ready);
  modport sink   (input valid, input a_value, input b_value, output ready);
endinterface

// ----- hdl/eeg_out_if.sv -----
// Result channel: valid/ready handshake carrying gcd and Bezout coefficients.
// Depends on eeg_pkg.
interface eeg_out_if import eeg_pkg::*; ();
  logic  valid;
  logic  ready;
  opnd_t gcd_value;
  coef_t coeff_a;
  coef_t coeff_b;

  modport source (output valid, output gcd_value, output coeff_a, output coeff_b,
                  input ready);
  modport sink   (input valid, input gcd_value, input coeff_a, input coeff_b,
                  output ready);
endinterface

// ----- hdl/eeg_div_step.sv -----
// One step of the shared unit: restoring division bit plus the quotient
// multiply-accumulate for both coefficients. Depends on eeg_pkg.
module eeg_div_step import eeg_pkg::*; (
  input  opnd_t rem_i,
  input  logic  dvd_msb_i,
  input  opnd_t divisor_i,
  input  coef_t xs_i,
  input  coef_t ys_i,
  input  coef_t prod_x_i,
  input  coef_t prod_y_i,
  output opnd_t rem_o,
  output coef_t prod_x_o,
  output coef_t prod_y_o
);

  logic [OPND_W:0] shifted;
  logic [OPND_W:0] diff;
  logic            qbit;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_i, dvd_msb_i};
  assign diff    = shifted - {1'b0, divisor_i};
  assign qbit    = ~diff[OPND_W];
  assign rem_o   = qbit ? diff[OPND_W-1:0] : shifted[OPND_W-1:0];

  // Quotient bits arrive MSB first: Horner form gives q*xs and q*ys
  assign prod_x_o = {prod_x_i[COEF_W-2:0], 1'b0} + (qbit ? xs_i : COEF_ZERO);
  assign prod_y_o = {prod_y_i[COEF_W-2:0], 1'b0} + (qbit ? ys_i : COEF_ZERO);

endmodule

// ----- hdl/extended_euclid_gcd_core.sv -----
// Extended Euclid gcd core: sequencer around the shared division step.
// Depends on eeg_pkg, eeg_in_if, eeg_out_if, eeg_div_step.
//
// Takes two unsigned operands and returns gcd(a,b) with signed Bezout
// coefficients so that coeff_a*a + coeff_b*b = gcd. One item is processed
// at a time; the operand channel is ready only while the sequencer is idle.
// Each Euclid step runs the bit-serial divider in ST_DIV and then shifts
// the remainder sequence in ST_UPDATE; there are at most 44 division steps
// for 31-bit operands, reached by consecutive Fibonacci numbers. A zero
// operand skips the divider and goes straight to ST_FIN. The result sits
// in an output register, so the next item can be taken while a finished
// result still waits for its transfer.
module extended_euclid_gcd_core import eeg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  eeg_in_if.sink           in_i,
  eeg_out_if.source        out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE,
    ST_FIN
  } state_e;

  state_e state_q;
  cnt_t   cnt_q;
  opnd_t  big_q, small_q, rem_q;
  coef_t  xb_q, yb_q, xs_q, ys_q, px_q, py_q;
  logic   out_valid_q;
  opnd_t  gcd_q;
  coef_t  ca_q, cb_q;

  opnd_t  rem_d;
  coef_t  px_d, py_d;
  logic   out_free;

  // Shared division / accumulate step
  eeg_div_step u_step (
    .rem_i     (rem_q),
    .dvd_msb_i (big_q[OPND_W-1]),
    .divisor_i (small_q),
    .xs_i      (xs_q),
    .ys_i      (ys_q),
    .prod_x_i  (px_q),
    .prod_y_i  (py_q),
    .rem_o     (rem_d),
    .prod_x_o  (px_d),
    .prod_y_o  (py_d)
  );

  assign out_free = !out_valid_q || out_o.ready;

  // Sequencer, datapath registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      big_q       <= '0;
      small_q     <= '0;
      rem_q       <= '0;
      xb_q        <= COEF_ZERO;
      yb_q        <= COEF_ZERO;
      xs_q        <= COEF_ZERO;
      ys_q        <= COEF_ZERO;
      px_q        <= COEF_ZERO;
      py_q        <= COEF_ZERO;
      out_valid_q <= 1'b0;
      gcd_q       <= '0;
      ca_q        <= COEF_ZERO;
      cb_q        <= COEF_ZERO;
    end else begin
      // result leaves on its transfer; in ST_FIN a new result takes its place
      if (out_valid_q && out_o.ready && state_q != ST_FIN) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_i.valid) begin
            rem_q <= '0;
            cnt_q <= '0;
            px_q  <= COEF_ZERO;
            py_q  <= COEF_ZERO;
            priority if (in_i.b_value == '0) begin
              small_q <= in_i.a_value;
              xs_q    <= COEF_ONE;
              ys_q    <= COEF_ZERO;
              state_q <= ST_FIN;
            end else if (in_i.a_value == '0) begin
              small_q <= in_i.b_value;
              xs_q    <= COEF_ZERO;
              ys_q    <= COEF_ONE;
              state_q <= ST_FIN;
            end else if (in_i.a_value < in_i.b_value) begin
              big_q   <= in_i.b_value;
              small_q <= in_i.a_value;
              xb_q    <= COEF_ZERO;
              yb_q    <= COEF_ONE;
              xs_q    <= COEF_ONE;
              ys_q    <= COEF_ZERO;
              state_q <= ST_DIV;
            end else begin
              big_q   <= in_i.a_value;
              small_q <= in_i.b_value;
              xb_q    <= COEF_ONE;
              yb_q    <= COEF_ZERO;
              xs_q    <= COEF_ZERO;
              ys_q    <= COEF_ONE;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle
          rem_q <= rem_d;
          px_q  <= px_d;
          py_q  <= py_d;
          big_q <= {big_q[OPND_W-2:0], 1'b0};
          cnt_q <= cnt_q + cnt_t'(1);
          if (cnt_q == cnt_t'(OPND_W - 1)) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (rem_q == '0) begin
            state_q <= ST_FIN;
          end else begin
            // shift the remainder sequence and its coefficients down
            big_q   <= small_q;
            small_q <= rem_q;
            xb_q    <= xs_q;
            yb_q    <= ys_q;
            xs_q    <= xb_q - px_q;
            ys_q    <= yb_q - py_q;
            rem_q   <= '0;
            cnt_q   <= '0;
            px_q    <= COEF_ZERO;
            py_q    <= COEF_ZERO;
            state_q <= ST_DIV;
          end
        end
        ST_FIN: begin
          // wait for the result register to free up
          if (out_free) begin
            gcd_q       <= small_q;
            ca_q        <= xs_q;
            cb_q        <= ys_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready      = (state_q == ST_IDLE);
  assign out_o.valid     = out_valid_q;
  assign out_o.gcd_value = gcd_q;
  assign out_o.coeff_a   = ca_q;
  assign out_o.coeff_b   = cb_q;

endmodule
